/* hdl/gbi_pkg.sv */
// shared types, codes and helpers of the gif block indexer
package gbi_pkg;

	localparam int OFFSET_WIDTH_DEF      = 32;
	localparam int FRAME_COUNT_WIDTH_DEF = 16;

	localparam int SKIP_WIDTH = 10;
	localparam int DIM_WIDTH  = 16;
	localparam int HDR_LEN    = 13;

	// signature bytes "GIF87a" / "GIF89a"
	localparam logic [7:0] SIG_G    = 8'h47;
	localparam logic [7:0] SIG_I    = 8'h49;
	localparam logic [7:0] SIG_F    = 8'h46;
	localparam logic [7:0] SIG_8    = 8'h38;
	localparam logic [7:0] SIG_7    = 8'h37;
	localparam logic [7:0] SIG_9    = 8'h39;
	localparam logic [7:0] SIG_A    = 8'h61;

	// block introducers and labels
	localparam logic [7:0] MARK_TRAILER = 8'h3b;
	localparam logic [7:0] MARK_EXT     = 8'h21;
	localparam logic [7:0] MARK_IMAGE   = 8'h2c;
	localparam logic [7:0] LABEL_GCE    = 8'hf9;

	// header byte positions
	localparam logic [3:0] HP_SIG0   = 4'd0;
	localparam logic [3:0] HP_SIG1   = 4'd1;
	localparam logic [3:0] HP_SIG2   = 4'd2;
	localparam logic [3:0] HP_SIG3   = 4'd3;
	localparam logic [3:0] HP_SIG4   = 4'd4;
	localparam logic [3:0] HP_SIG5   = 4'd5;
	localparam logic [3:0] HP_W_LO   = 4'd6;
	localparam logic [3:0] HP_W_HI   = 4'd7;
	localparam logic [3:0] HP_H_LO   = 4'd8;
	localparam logic [3:0] HP_H_HI   = 4'd9;
	localparam logic [3:0] HP_PACKED = 4'd10;
	localparam logic [3:0] HP_LAST   = 4'(HDR_LEN - 1);

	// image descriptor bytes after the separator
	localparam logic [SKIP_WIDTH-1:0] DESC_LEN = SKIP_WIDTH'(9);

	typedef enum logic [3:0] {
		PH_HEADER    = 4'd0,
		PH_GCT       = 4'd1,
		PH_MARKER    = 4'd2,
		PH_EXT_LABEL = 4'd3,
		PH_EXT_LEN   = 4'd4,
		PH_EXT_DATA  = 4'd5,
		PH_DESC      = 4'd6,
		PH_LCT       = 4'd7,
		PH_LZW_MIN   = 4'd8,
		PH_IMG_LEN   = 4'd9,
		PH_IMG_DATA  = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		EV_HEADER = 2'd0,
		EV_FRAME  = 2'd1,
		EV_DONE   = 2'd2,
		EV_ERROR  = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_SIGNATURE = 3'd1,
		ERR_CANVAS    = 3'd2,
		ERR_MARKER    = 3'd3,
		ERR_TRUNCATED = 3'd4,
		ERR_NO_FRAMES = 3'd5
	} err_t;

	// header checker results for one byte
	typedef struct packed {
		err_t                  err;
		logic [DIM_WIDTH-1:0]  width;
		logic [DIM_WIDTH-1:0]  height;
		logic                  skip_load;
		logic [SKIP_WIDTH-1:0] skip;
		logic                  last_hdr_byte;
	} hdr_res_t;

	// colour table size in bytes from a packed field
	function automatic logic [SKIP_WIDTH-1:0] table_skip(input logic [7:0] packed_b);
		logic [3:0] sh;
		sh = {1'b0, packed_b[2:0]} + 4'd1;
		if (!packed_b[7])
			table_skip = '0;
		else
			table_skip = SKIP_WIDTH'(3) << sh;
	endfunction

endpackage

/* hdl/gbi_data_if.sv */
// byte channel into the gif block indexer
interface gbi_data_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

/* hdl/gbi_rec_if.sv */
// record channel out of the gif block indexer
interface gbi_rec_if #(
	parameter int OFS_W = 32,
	parameter int FRM_W = 16
);
	logic             valid;
	logic             ready;
	logic [1:0]       event_res;
	logic [2:0]       fault_code;
	logic [15:0]      scr_width;
	logic [15:0]      scr_height;
	logic [OFS_W-1:0] prefix_len;
	logic [FRM_W-1:0] frame_number;
	logic [OFS_W-1:0] control_begin;
	logic [OFS_W-1:0] control_end;
	logic [OFS_W-1:0] img_start;
	logic [OFS_W-1:0] img_stop;

	modport source (output valid, output event_res, output fault_code, output scr_width,
		output scr_height, output prefix_len, output frame_number, output control_begin,
		output control_end, output img_start, output img_stop, input ready);
	modport sink (input valid, input event_res, input fault_code, input scr_width,
		input scr_height, input prefix_len, input frame_number, input control_begin,
		input control_end, input img_start, input img_stop, output ready);
endinterface

/* hdl/gif_block_indexer_top.sv */
// top level of the gif block indexer: byte walker and record register
//
// The block takes a GIF file one byte per word on data_ch and walks its container
// structure: signature, logical screen, global colour table, extension blocks and
// image descriptors with their local colour tables and data sub-blocks. It sends a
// header record once the prefix is passed, one frame record per image (with the span
// of the last graphic control extension since the prior image, and its own span),
// and a closing record, done or error, on rec_ch. A byte with first_byte set restarts
// parsing at offset 0; after a closing record bytes are swallowed until such a restart.
// A byte is taken in every clock cycle as long as the record register is free or being
// emptied in the same cycle, so the sustained rate is one byte per cycle; the record
// caused by a byte is on rec_ch in the cycle after that byte is taken. Offsets are
// OFFSET_WIDTH bits and wrap; the frame counter saturates at FRAME_COUNT_WIDTH bits.
module gif_block_indexer_top #(
	parameter int OFFSET_WIDTH      = gbi_pkg::OFFSET_WIDTH_DEF,
	parameter int FRAME_COUNT_WIDTH = gbi_pkg::FRAME_COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gbi_data_if.sink   data_ch,
	gbi_rec_if.source  rec_ch
);
	import gbi_pkg::*;

	localparam int OW = OFFSET_WIDTH;
	localparam int FW = FRAME_COUNT_WIDTH;

	// parser state
	phase_t                phase_q;
	logic [OW-1:0]         pos_q;
	logic [SKIP_WIDTH-1:0] skip_q;
	logic [DIM_WIDTH-1:0]  width_q;
	logic [DIM_WIDTH-1:0]  height_q;
	logic [OW-1:0]         ext_start_q;
	logic                  ext_ctl_q;
	logic [OW-1:0]         ctl_begin_q;
	logic [OW-1:0]         ctl_end_q;
	logic [OW-1:0]         img_begin_q;
	logic [FW-1:0]         frames_q;
	logic                  finished_q;

	// state as seen by the current byte (cleared by first_byte)
	phase_t                cur_phase;
	logic [OW-1:0]         cur_pos;
	logic [SKIP_WIDTH-1:0] cur_skip;
	logic [DIM_WIDTH-1:0]  cur_width;
	logic [DIM_WIDTH-1:0]  cur_height;
	logic [OW-1:0]         cur_ext_start;
	logic                  cur_ext_ctl;
	logic [OW-1:0]         cur_ctl_begin;
	logic [OW-1:0]         cur_ctl_end;
	logic [OW-1:0]         cur_img_begin;
	logic [FW-1:0]         cur_frames;
	logic                  cur_finished;

	// next state
	phase_t                n_phase;
	logic [OW-1:0]         n_pos;
	logic [SKIP_WIDTH-1:0] n_skip;
	logic [DIM_WIDTH-1:0]  n_width;
	logic [DIM_WIDTH-1:0]  n_height;
	logic [OW-1:0]         n_ext_start;
	logic                  n_ext_ctl;
	logic [OW-1:0]         n_ctl_begin;
	logic [OW-1:0]         n_ctl_end;
	logic [OW-1:0]         n_img_begin;
	logic [FW-1:0]         n_frames;
	logic                  n_finished;

	// record produced by the current byte
	logic                  r_valid;
	event_t                r_event;
	err_t                  r_err;
	logic [OW-1:0]         r_prefix;
	logic [FW-1:0]         r_fnum;
	logic [OW-1:0]         r_cb;
	logic [OW-1:0]         r_ce;
	logic [OW-1:0]         r_ib;
	logic [OW-1:0]         r_ie;

	// record register
	logic                  rec_valid_q;
	event_t                rec_event_q;
	err_t                  rec_err_q;
	logic [DIM_WIDTH-1:0]  rec_width_q;
	logic [DIM_WIDTH-1:0]  rec_height_q;
	logic [OW-1:0]         rec_prefix_q;
	logic [FW-1:0]         rec_fnum_q;
	logic [OW-1:0]         rec_cb_q;
	logic [OW-1:0]         rec_ce_q;
	logic [OW-1:0]         rec_ib_q;
	logic [OW-1:0]         rec_ie_q;

	logic                  take;
	logic [7:0]            b;
	logic [OW-1:0]         pos_next;
	logic [SKIP_WIDTH-1:0] skip_dec;
	logic [SKIP_WIDTH-1:0] b_table;
	hdr_res_t              hdr;

	// a word is taken whenever the record register is free or drains this cycle
	assign data_ch.ready = !rec_valid_q || rec_ch.ready;
	assign take          = data_ch.valid && data_ch.ready;
	assign b             = data_ch.data_byte;

	// first_byte behaves as a reset ahead of the byte it marks
	always_comb begin
		if (data_ch.first_byte) begin
			cur_phase     = PH_HEADER;
			cur_pos       = '0;
			cur_skip      = '0;
			cur_width     = '0;
			cur_height    = '0;
			cur_ext_start = '0;
			cur_ext_ctl   = 1'b0;
			cur_ctl_begin = '0;
			cur_ctl_end   = '0;
			cur_img_begin = '0;
			cur_frames    = '0;
			cur_finished  = 1'b0;
		end else begin
			cur_phase     = phase_q;
			cur_pos       = pos_q;
			cur_skip      = skip_q;
			cur_width     = width_q;
			cur_height    = height_q;
			cur_ext_start = ext_start_q;
			cur_ext_ctl   = ext_ctl_q;
			cur_ctl_begin = ctl_begin_q;
			cur_ctl_end   = ctl_end_q;
			cur_img_begin = img_begin_q;
			cur_frames    = frames_q;
			cur_finished  = finished_q;
		end
	end

	assign pos_next = cur_pos + OW'(1);
	assign skip_dec = cur_skip - SKIP_WIDTH'(1);
	assign b_table  = table_skip(b);

	// the first thirteen bytes are checked in their own unit
	gbi_header u_header (
		.data_byte  (b),
		.pos_lo     (cur_pos[3:0]),
		.pos_in_hdr (cur_pos[OW-1:4] == '0),
		.width      (cur_width),
		.height     (cur_height),
		.res        (hdr)
	);

	// one parse step per byte
	always_comb begin
		n_phase     = cur_phase;
		n_pos       = pos_next;
		n_skip      = cur_skip;
		n_width     = cur_width;
		n_height    = cur_height;
		n_ext_start = cur_ext_start;
		n_ext_ctl   = cur_ext_ctl;
		n_ctl_begin = cur_ctl_begin;
		n_ctl_end   = cur_ctl_end;
		n_img_begin = cur_img_begin;
		n_frames    = cur_frames;
		n_finished  = cur_finished;
		r_valid     = 1'b0;
		r_event     = EV_HEADER;
		r_err       = ERR_NONE;
		r_prefix    = '0;
		r_fnum      = '0;
		r_cb        = '0;
		r_ce        = '0;
		r_ib        = '0;
		r_ie        = '0;

		case (cur_phase)
			PH_HEADER: begin
				n_width  = hdr.width;
				n_height = hdr.height;
				r_err    = hdr.err;
				if (hdr.skip_load) n_skip = hdr.skip;
				if (hdr.last_hdr_byte) begin
					if (cur_skip != '0) begin
						n_phase = PH_GCT;
					end else begin
						r_valid  = 1'b1;
						r_event  = EV_HEADER;
						r_prefix = pos_next;
						n_phase  = PH_MARKER;
					end
				end
			end
			PH_GCT: begin
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					r_valid  = 1'b1;
					r_event  = EV_HEADER;
					r_prefix = pos_next;
					n_phase  = PH_MARKER;
				end
			end
			PH_MARKER: begin
				if (b == MARK_TRAILER) begin
					if (cur_frames != '0) begin
						r_valid = 1'b1;
						r_event = EV_DONE;
					end else begin
						r_err = ERR_NO_FRAMES;
					end
				end else if (b == MARK_EXT) begin
					n_ext_start = cur_pos;
					n_phase     = PH_EXT_LABEL;
				end else if (b == MARK_IMAGE) begin
					n_img_begin = cur_pos;
					n_skip      = DESC_LEN;
					n_phase     = PH_DESC;
				end else begin
					r_err = ERR_MARKER;
				end
			end
			PH_EXT_LABEL: begin
				n_ext_ctl = (b == LABEL_GCE);
				n_phase   = PH_EXT_LEN;
			end
			PH_EXT_LEN: begin
				if (b == 8'h00) begin
					// block terminator: a control extension becomes pending
					if (cur_ext_ctl) begin
						n_ctl_begin = cur_ext_start;
						n_ctl_end   = pos_next;
					end
					n_phase = PH_MARKER;
				end else begin
					n_skip  = SKIP_WIDTH'(b);
					n_phase = PH_EXT_DATA;
				end
			end
			PH_EXT_DATA: begin
				n_skip = skip_dec;
				if (skip_dec == '0) n_phase = PH_EXT_LEN;
			end
			PH_DESC: begin
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					// last descriptor byte holds the local table flag
					n_skip  = b_table;
					n_phase = (b_table != '0) ? PH_LCT : PH_LZW_MIN;
				end
			end
			PH_LCT: begin
				n_skip = skip_dec;
				if (skip_dec == '0) n_phase = PH_LZW_MIN;
			end
			PH_LZW_MIN: n_phase = PH_IMG_LEN;
			PH_IMG_LEN: begin
				if (b == 8'h00) begin
					r_valid     = 1'b1;
					r_event     = EV_FRAME;
					r_fnum      = cur_frames;
					r_cb        = cur_ctl_begin;
					r_ce        = cur_ctl_end;
					r_ib        = cur_img_begin;
					r_ie        = pos_next;
					if (cur_frames != '1) n_frames = cur_frames + FW'(1);
					n_ctl_begin = '0;
					n_ctl_end   = '0;
					n_phase     = PH_MARKER;
				end else begin
					n_skip  = SKIP_WIDTH'(b);
					n_phase = PH_IMG_DATA;
				end
			end
			PH_IMG_DATA: begin
				n_skip = skip_dec;
				if (skip_dec == '0) n_phase = PH_IMG_LEN;
			end
			default: r_err = ERR_MARKER;
		endcase

		// closing records: an error wins, then done, then an early end of file
		if (r_err != ERR_NONE) begin
			r_valid    = 1'b1;
			r_event    = EV_ERROR;
			n_finished = 1'b1;
		end else if (r_valid && r_event == EV_DONE) begin
			n_finished = 1'b1;
		end else if (data_ch.last_byte) begin
			r_valid    = 1'b1;
			r_event    = EV_ERROR;
			r_err      = ERR_TRUNCATED;
			n_finished = 1'b1;
		end

		if (r_event != EV_HEADER) r_prefix = '0;
		if (r_event != EV_FRAME) begin
			r_fnum = '0;
			r_cb   = '0;
			r_ce   = '0;
			r_ib   = '0;
			r_ie   = '0;
		end

		// once finished the byte changes nothing and gives no record
		if (cur_finished) begin
			n_phase     = cur_phase;
			n_pos       = cur_pos;
			n_skip      = cur_skip;
			n_width     = cur_width;
			n_height    = cur_height;
			n_ext_start = cur_ext_start;
			n_ext_ctl   = cur_ext_ctl;
			n_ctl_begin = cur_ctl_begin;
			n_ctl_end   = cur_ctl_end;
			n_img_begin = cur_img_begin;
			n_frames    = cur_frames;
			n_finished  = cur_finished;
			r_valid     = 1'b0;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			skip_q      <= '0;
			width_q     <= '0;
			height_q    <= '0;
			ext_start_q <= '0;
			ext_ctl_q   <= 1'b0;
			ctl_begin_q <= '0;
			ctl_end_q   <= '0;
			img_begin_q <= '0;
			frames_q    <= '0;
			finished_q  <= 1'b0;
		end else if (take) begin
			phase_q     <= n_phase;
			pos_q       <= n_pos;
			skip_q      <= n_skip;
			width_q     <= n_width;
			height_q    <= n_height;
			ext_start_q <= n_ext_start;
			ext_ctl_q   <= n_ext_ctl;
			ctl_begin_q <= n_ctl_begin;
			ctl_end_q   <= n_ctl_end;
			img_begin_q <= n_img_begin;
			frames_q    <= n_frames;
			finished_q  <= n_finished;
		end
	end

	// record valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (take && r_valid) begin
			rec_valid_q <= 1'b1;
		end else if (rec_ch.ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	// record payload, loaded only with a new record
	always_ff @(posedge clk) begin
		if (take && r_valid) begin
			rec_event_q  <= r_event;
			rec_err_q    <= r_err;
			rec_width_q  <= n_width;
			rec_height_q <= n_height;
			rec_prefix_q <= r_prefix;
			rec_fnum_q   <= r_fnum;
			rec_cb_q     <= r_cb;
			rec_ce_q     <= r_ce;
			rec_ib_q     <= r_ib;
			rec_ie_q     <= r_ie;
		end
	end

	assign rec_ch.valid         = rec_valid_q;
	assign rec_ch.event_res     = rec_event_q;
	assign rec_ch.fault_code    = rec_err_q;
	assign rec_ch.scr_width     = rec_width_q;
	assign rec_ch.scr_height    = rec_height_q;
	assign rec_ch.prefix_len    = rec_prefix_q;
	assign rec_ch.frame_number  = rec_fnum_q;
	assign rec_ch.control_begin = rec_cb_q;
	assign rec_ch.control_end   = rec_ce_q;
	assign rec_ch.img_start     = rec_ib_q;
	assign rec_ch.img_stop      = rec_ie_q;

endmodule

/* hdl/gbi_header.sv */
// header byte checker: signature, screen size and global table flag
module gbi_header (
	input  logic [7:0]                   data_byte,
	input  logic [3:0]                   pos_lo,
	input  logic                         pos_in_hdr,
	input  logic [gbi_pkg::DIM_WIDTH-1:0] width,
	input  logic [gbi_pkg::DIM_WIDTH-1:0] height,
	output gbi_pkg::hdr_res_t            res
);
	import gbi_pkg::*;

	always_comb begin
		res = '{err: ERR_NONE, width: width, height: height, skip_load: 1'b0,
			skip: '0, last_hdr_byte: 1'b0};
		if (pos_in_hdr) begin
			case (pos_lo)
				HP_SIG0: begin
					if (data_byte != SIG_G) res.err = ERR_SIGNATURE;
				end
				HP_SIG1: begin
					if (data_byte != SIG_I) res.err = ERR_SIGNATURE;
				end
				HP_SIG2: begin
					if (data_byte != SIG_F) res.err = ERR_SIGNATURE;
				end
				HP_SIG3: begin
					if (data_byte != SIG_8) res.err = ERR_SIGNATURE;
				end
				HP_SIG4: begin
					if (data_byte != SIG_7 && data_byte != SIG_9) res.err = ERR_SIGNATURE;
				end
				HP_SIG5: begin
					if (data_byte != SIG_A) res.err = ERR_SIGNATURE;
				end
				HP_W_LO: res.width = {8'h00, data_byte};
				HP_W_HI: res.width = width | {data_byte, 8'h00};
				HP_H_LO: res.height = {8'h00, data_byte};
				HP_H_HI: begin
					res.height = height | {data_byte, 8'h00};
					if (width == '0 || res.height == '0) res.err = ERR_CANVAS;
				end
				HP_PACKED: begin
					res.skip_load = 1'b1;
					res.skip      = table_skip(data_byte);
				end
				HP_LAST: res.last_hdr_byte = 1'b1;
				default: ;
			endcase
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// testbench of the gif block indexer: random gif files checked against a byte-walk predictor
module tb_top;
	import gbi_pkg::*;

	localparam int          HALF_PERIOD  = 6;
	localparam int          RESET_CYCLES = 8;
	localparam int          RANDOM_BYTES = 1400;
	localparam int unsigned RUN_LIMIT    = 200000;
	localparam int unsigned HOLD_AT      = 700;
	localparam int unsigned HOLD_LEN     = 250;
	localparam int unsigned CALM_FROM    = 1100;
	localparam int unsigned CALM_TO      = 1600;
	localparam int          TAIL_CYCLES  = 16;
	localparam int          IDLE_PCT     = 6;

	// one word of the byte channel
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} gif_byte_t;

	// one word of the record channel
	typedef struct packed {
		logic [1:0]  ev;
		logic [2:0]  err;
		logic [15:0] width;
		logic [15:0] height;
		logic [31:0] prefix_len;
		logic [15:0] frame_no;
		logic [31:0] ctl_begin;
		logic [31:0] ctl_end;
		logic [31:0] img_begin;
		logic [31:0] img_end;
	} gif_rec_t;

	logic        clk;
	logic        arst_n;
	int unsigned cyc = 0;
	int          mismatches = 0;
	int          hold_left;
	gif_byte_t   byte_out;

	gif_byte_t  bytes_pending[$];
	gif_rec_t   records_due[$];
	logic [7:0] file_buf[$];

	// walker state, mirrors what the block keeps
	phase_t      ph;
	logic [31:0] pos_n;
	logic [9:0]  skip_left;
	logic [15:0] scr_w;
	logic [15:0] scr_h;
	logic [31:0] ext_at;
	logic        ext_gce;
	logic [31:0] gce_start;
	logic [31:0] gce_end;
	logic [31:0] img_at;
	logic [15:0] frame_cnt;
	logic        closed;

	gbi_data_if data_ch ();
	gbi_rec_if #(.OFS_W(32), .FRM_W(16)) rec_ch ();

	gif_block_indexer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.data_ch(data_ch),
		.rec_ch (rec_ch)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == RUN_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// colour table length in bytes from a packed flags byte
	function automatic logic [9:0] color_table_bytes(input logic [7:0] flags);
		if (!flags[7])
			return '0;
		return 10'd3 << ({1'b0, flags[2:0]} + 4'd1);
	endfunction

	function automatic void clear_walk();
		ph        = PH_HEADER;
		pos_n     = '0;
		skip_left = '0;
		scr_w     = '0;
		scr_h     = '0;
		ext_at    = '0;
		ext_gce   = 1'b0;
		gce_start = '0;
		gce_end   = '0;
		img_at    = '0;
		frame_cnt = '0;
		closed    = 1'b0;
	endfunction

	// random idle decision, switched off inside the calm window
	function automatic bit take_break();
		return (cyc < CALM_FROM || cyc >= CALM_TO) && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// walk one byte and queue the record it causes, if any
	task automatic index_byte(input logic [7:0] b, input logic first, input logic last);
		gif_rec_t    r;
		logic [31:0] ofs;
		logic [31:0] ofs_next;
		logic [2:0]  er;
		logic        emit;
		if (first)
			clear_walk();
		// closed file: swallow until a restart
		if (closed)
			return;
		ofs      = pos_n;
		ofs_next = pos_n + 32'd1;
		r        = '0;
		er       = ERR_NONE;
		emit     = 1'b0;
		case (ph)
		PH_HEADER: begin
			case (ofs)
			HP_SIG0: if (b != SIG_G) er = ERR_SIGNATURE;
			HP_SIG1: if (b != SIG_I) er = ERR_SIGNATURE;
			HP_SIG2: if (b != SIG_F) er = ERR_SIGNATURE;
			HP_SIG3: if (b != SIG_8) er = ERR_SIGNATURE;
			HP_SIG4: if (b != SIG_7 && b != SIG_9) er = ERR_SIGNATURE;
			HP_SIG5: if (b != SIG_A) er = ERR_SIGNATURE;
			HP_W_LO: scr_w = {8'h00, b};
			HP_W_HI: scr_w[15:8] = b;
			HP_H_LO: scr_h = {8'h00, b};
			HP_H_HI: begin
				scr_h[15:8] = b;
				if (scr_w == '0 || scr_h == '0)
					er = ERR_CANVAS;
			end
			HP_PACKED: skip_left = color_table_bytes(b);
			HP_LAST: begin
				if (skip_left != '0) begin
					ph = PH_GCT;
				end else begin
					emit         = 1'b1;
					r.ev         = EV_HEADER;
					r.prefix_len = ofs_next;
					ph           = PH_MARKER;
				end
			end
			default: ;
			endcase
		end
		PH_GCT: begin
			skip_left = skip_left - 10'd1;
			if (skip_left == '0) begin
				emit         = 1'b1;
				r.ev         = EV_HEADER;
				r.prefix_len = ofs_next;
				ph           = PH_MARKER;
			end
		end
		PH_MARKER: begin
			if (b == MARK_TRAILER) begin
				if (frame_cnt != '0) begin
					emit = 1'b1;
					r.ev = EV_DONE;
				end else begin
					er = ERR_NO_FRAMES;
				end
			end else if (b == MARK_EXT) begin
				ext_at = ofs;
				ph     = PH_EXT_LABEL;
			end else if (b == MARK_IMAGE) begin
				img_at    = ofs;
				skip_left = DESC_LEN;
				ph        = PH_DESC;
			end else begin
				er = ERR_MARKER;
			end
		end
		PH_EXT_LABEL: begin
			ext_gce = (b == LABEL_GCE);
			ph      = PH_EXT_LEN;
		end
		PH_EXT_LEN: begin
			if (b == 8'h00) begin
				// only a graphic control extension updates the pending span
				if (ext_gce) begin
					gce_start = ext_at;
					gce_end   = ofs_next;
				end
				ph = PH_MARKER;
			end else begin
				skip_left = {2'b00, b};
				ph        = PH_EXT_DATA;
			end
		end
		PH_EXT_DATA: begin
			skip_left = skip_left - 10'd1;
			if (skip_left == '0)
				ph = PH_EXT_LEN;
		end
		PH_DESC: begin
			skip_left = skip_left - 10'd1;
			// last descriptor byte carries the local table flags
			if (skip_left == '0) begin
				skip_left = color_table_bytes(b);
				ph        = (skip_left != '0) ? PH_LCT : PH_LZW_MIN;
			end
		end
		PH_LCT: begin
			skip_left = skip_left - 10'd1;
			if (skip_left == '0)
				ph = PH_LZW_MIN;
		end
		PH_LZW_MIN: ph = PH_IMG_LEN;
		PH_IMG_LEN: begin
			if (b == 8'h00) begin
				emit        = 1'b1;
				r.ev        = EV_FRAME;
				r.frame_no  = frame_cnt;
				r.ctl_begin = gce_start;
				r.ctl_end   = gce_end;
				r.img_begin = img_at;
				r.img_end   = ofs_next;
				// frame counter saturates
				if (frame_cnt != 16'hffff)
					frame_cnt = frame_cnt + 16'd1;
				gce_start = '0;
				gce_end   = '0;
				ph        = PH_MARKER;
			end else begin
				skip_left = {2'b00, b};
				ph        = PH_IMG_DATA;
			end
		end
		PH_IMG_DATA: begin
			skip_left = skip_left - 10'd1;
			if (skip_left == '0)
				ph = PH_IMG_LEN;
		end
		default: er = ERR_MARKER;
		endcase
		pos_n = ofs_next;

		// error beats done, done beats truncation, truncation beats header or frame
		if (er != ERR_NONE) begin
			r.ev   = EV_ERROR;
			emit   = 1'b1;
			closed = 1'b1;
		end else if (emit && r.ev == EV_DONE) begin
			closed = 1'b1;
		end else if (last) begin
			r.ev   = EV_ERROR;
			er     = ERR_TRUNCATED;
			emit   = 1'b1;
			closed = 1'b1;
		end
		if (!emit)
			return;
		if (r.ev != EV_HEADER)
			r.prefix_len = '0;
		if (r.ev != EV_FRAME) begin
			r.frame_no  = '0;
			r.ctl_begin = '0;
			r.ctl_end   = '0;
			r.img_begin = '0;
			r.img_end   = '0;
		end
		r.err    = er;
		r.width  = scr_w;
		r.height = scr_h;
		records_due = {records_due, r};
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
		end
	endtask

	task automatic check_record();
		gif_rec_t got;
		gif_rec_t want;
		got.ev         = rec_ch.event_res;
		got.err        = rec_ch.fault_code;
		got.width      = rec_ch.scr_width;
		got.height     = rec_ch.scr_height;
		got.prefix_len = rec_ch.prefix_len;
		got.frame_no   = rec_ch.frame_number;
		got.ctl_begin  = rec_ch.control_begin;
		got.ctl_end    = rec_ch.control_end;
		got.img_begin  = rec_ch.img_start;
		got.img_end    = rec_ch.img_stop;
		if (records_due.size() == 0) begin
			mismatches++;
			$display("%0t: record expected none, got event %0d error %0d", $time, got.ev,
				got.err);
			return;
		end
		want = records_due.pop_front();
		check_field("event_res", want.ev, got.ev);
		check_field("fault_code", want.err, got.err);
		check_field("scr_width", want.width, got.width);
		check_field("scr_height", want.height, got.height);
		check_field("prefix_len", want.prefix_len, got.prefix_len);
		check_field("frame_number", want.frame_no, got.frame_no);
		check_field("control_begin", want.ctl_begin, got.ctl_begin);
		check_field("control_end", want.ctl_end, got.ctl_end);
		check_field("img_start", want.img_begin, got.img_begin);
		check_field("img_stop", want.img_end, got.img_end);
	endtask

	// move the file buffer into the pending words, flags on its ends
	task automatic flush_file(input bit mark_first, input bit mark_last);
		gif_byte_t item;
		for (int i = 0; i < file_buf.size(); i++) begin
			item.data  = file_buf[i];
			item.first = mark_first && (i == 0);
			item.last  = mark_last && (i == file_buf.size() - 1);
			bytes_pending = {bytes_pending, item};
		end
		file_buf.delete();
	endtask

	// length-prefixed sub-blocks and their terminator
	task automatic put_sub_blocks(input int most);
		int len;
		repeat ($urandom_range(most)) begin
			len = ($urandom_range(29) == 0) ? 255 : $urandom_range(8, 1);
			file_buf = {file_buf, 8'(len)};
			repeat (len)
				file_buf = {file_buf, 8'($urandom)};
		end
		file_buf = {file_buf, 8'h00};
	endtask

	task automatic put_table(input logic [7:0] flags);
		repeat (color_table_bytes(flags))
			file_buf = {file_buf, 8'($urandom)};
	endtask

	// canvas size with the extremes weighted up
	function automatic logic [15:0] pick_dim();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return 16'h0000;
		if (r < 3)
			return 16'hffff;
		if (r < 5)
			return 16'h0001;
		return 16'($urandom);
	endfunction

	// byte driver: predicts each accepted word, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_ch.valid      <= 1'b0;
			data_ch.data_byte  <= 8'h00;
			data_ch.first_byte <= 1'b0;
			data_ch.last_byte  <= 1'b0;
		end else begin
			if (data_ch.valid && data_ch.ready)
				index_byte(data_ch.data_byte, data_ch.first_byte, data_ch.last_byte);
			// slot is free or being emptied now
			if (!data_ch.valid || data_ch.ready) begin
				if (bytes_pending.size() != 0 && !take_break()) begin
					byte_out            = bytes_pending.pop_front();
					data_ch.valid      <= 1'b1;
					data_ch.data_byte  <= byte_out.data;
					data_ch.first_byte <= byte_out.first;
					data_ch.last_byte  <= byte_out.last;
				end else begin
					data_ch.valid <= 1'b0;
				end
			end
		end
	end

	// record monitor: checks each accepted word, drives ready with a long hold-off once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_ch.ready <= 1'b0;
			hold_left    <= 0;
		end else begin
			if (rec_ch.valid && rec_ch.ready)
				check_record();
			if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				rec_ch.ready <= 1'b0;
			end else if (cyc == HOLD_AT) begin
				// block fills its record register and must stall the byte side
				hold_left    <= HOLD_LEN;
				rec_ch.ready <= 1'b0;
			end else begin
				rec_ch.ready <= !take_break();
			end
		end
	end

	initial begin : stimulus
		int          random_bytes;
		int          kind;
		int          cut;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  flags;
		bit          mark_last;

		arst_n <= 1'b0;
		clear_walk();
		random_bytes = 0;

		// no first-byte flag after reset: parsed from offset 0, bad second signature byte,
		// then a byte that the closed walker swallows
		file_buf = {SIG_G, 8'h58, 8'h00};
		flush_file(1'b0, 1'b0);
		// zero canvas width
		file_buf = {SIG_G, SIG_I, SIG_F, SIG_8, SIG_9, SIG_A, 8'h00, 8'h00, 8'h05, 8'h00};
		flush_file(1'b1, 1'b0);
		// one-byte file, truncated
		file_buf = {SIG_G};
		flush_file(1'b1, 1'b1);
		// widest canvas, trailer with no frames, last flag on the trailer
		file_buf = {SIG_G, SIG_I, SIG_F, SIG_8, SIG_7, SIG_A, 8'hff, 8'hff, 8'hff, 8'hff,
			8'h00, 8'h00, 8'h00, MARK_TRAILER};
		flush_file(1'b1, 1'b1);
		// smallest canvas, unknown block introducer
		file_buf = {SIG_G, SIG_I, SIG_F, SIG_8, SIG_9, SIG_A, 8'h01, 8'h00, 8'h01, 8'h00,
			8'h00, 8'hff, 8'hff, 8'h00};
		flush_file(1'b1, 1'b0);

		// random files: mostly well formed, some cut short or with a byte hit
		while (random_bytes < RANDOM_BYTES) begin
			w     = pick_dim();
			h     = pick_dim();
			flags = 8'($urandom);
			if ($urandom_range(1) == 0)
				flags[7] = 1'b0;
			else
				flags[2:0] = ($urandom_range(24) == 0) ? 3'd7 : 3'($urandom_range(2));
			file_buf = {SIG_G, SIG_I, SIG_F, SIG_8, ($urandom_range(1) != 0) ? SIG_9 : SIG_7,
				SIG_A, w[7:0], w[15:8], h[7:0], h[15:8], flags, 8'($urandom), 8'($urandom)};
			put_table(flags);
			repeat ($urandom_range(5)) begin
				kind = $urandom_range(19);
				if (kind < 7) begin
					// extension, mostly graphic control
					file_buf = {file_buf, MARK_EXT};
					file_buf = {file_buf,
						($urandom_range(9) < 6) ? LABEL_GCE : 8'($urandom)};
					put_sub_blocks(2);
				end else if (kind == 19) begin
					// stray byte where a block introducer belongs
					file_buf = {file_buf, 8'($urandom)};
				end else begin
					// image descriptor, optional local table, lzw size, data sub-blocks
					file_buf = {file_buf, MARK_IMAGE};
					repeat (8)
						file_buf = {file_buf, 8'($urandom)};
					flags = 8'($urandom);
					if ($urandom_range(9) < 7)
						flags[7] = 1'b0;
					else
						flags[2:0] = 3'($urandom_range(2));
					file_buf = {file_buf, flags};
					put_table(flags);
					file_buf = {file_buf, 8'($urandom_range(8, 2))};
					put_sub_blocks(3);
				end
			end
			file_buf = {file_buf, MARK_TRAILER};

			mark_last = 1'b1;
			kind      = $urandom_range(9);
			if (kind <= 1) begin
				// cut short; without the last flag the next file restarts mid-walk
				cut = $urandom_range(file_buf.size() - 1, 1);
				while (file_buf.size() > cut)
					file_buf.delete(file_buf.size() - 1);
				mark_last = (kind == 0);
			end else if (kind == 2) begin
				file_buf[$urandom_range(file_buf.size() - 1)] = 8'($urandom);
			end
			random_bytes += file_buf.size();
			// bytes after the trailer are swallowed
			if (kind == 3) begin
				repeat ($urandom_range(4, 1))
					file_buf = {file_buf, 8'($urandom)};
			end
			flush_file(1'b1, mark_last);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all words sent and every record seen
		while (bytes_pending.size() != 0 || data_ch.valid || records_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* sim.f */
hdl/gbi_pkg.sv
hdl/gbi_data_if.sv
hdl/gbi_rec_if.sv
hdl/gbi_header.sv
hdl/gif_block_indexer_top.sv
tb/tb_top.sv
